// ===== hdl/mmid_pkg.sv =====
// ----------------------------------------------------------------------------
// mmid_pkg
// Shared types and constants of the mask/match instruction decoder.
// ----------------------------------------------------------------------------
package mmid_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned SlotW      = 7;
  localparam int unsigned MatchIdxW  = 7;
  localparam int unsigned EntryCntW  = 8;
  localparam int unsigned RegW       = 5;
  localparam int unsigned CondW      = 4;

  // request kinds
  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // instruction field constants
  localparam logic [WordW-1:0] Simm13Ext = 32'hffffe000;
  localparam logic [WordW-1:0] Disp22Ext = 32'hffc00000;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] instr_word;
    logic [WordW-1:0] src1_value;
    logic [WordW-1:0] src2_value;
    logic [SlotW-1:0] entry_slot;
    logic [WordW-1:0] entry_mask;
    logic [WordW-1:0] entry_pattern;
  } mmid_req_t;

  typedef struct packed {
    logic                 matched;
    logic [MatchIdxW-1:0] match_index;
    logic [RegW-1:0]      dest_reg;
    logic [RegW-1:0]      src1_reg;
    logic [RegW-1:0]      src2_reg;
    logic                 uses_immediate;
    logic [CondW-1:0]     cond_code;
    logic [WordW-1:0]     eff_address;
    logic [WordW-1:0]     branch_disp;
    logic [WordW-1:0]     call_disp;
    logic [WordW-1:0]     entry_hits;
    logic [WordW-1:0]     total_hits;
  } mmid_rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             is_load;
    logic [WordW-1:0] instr_word;
    logic [RegW-1:0]  dest_reg;
    logic [RegW-1:0]  src1_reg;
    logic [RegW-1:0]  src2_reg;
    logic             uses_immediate;
    logic [CondW-1:0] cond_code;
    logic [WordW-1:0] eff_address;
    logic [WordW-1:0] branch_disp;
    logic [WordW-1:0] call_disp;
    logic [SlotW-1:0] entry_slot;
    logic [WordW-1:0] entry_mask;
    logic [WordW-1:0] entry_pattern;
  } mmid_task_t;

endpackage

// ===== hdl/mmid_ram.sv =====
// ----------------------------------------------------------------------------
// mmid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mmid_front.sv =====
// ----------------------------------------------------------------------------
// mmid_front
// Classifies an accepted request and splits an instruction into its fields.
// ----------------------------------------------------------------------------
module mmid_front import mmid_pkg::*; (
  input  mmid_req_t  req_i,
  output mmid_task_t task_o
);

  logic [WordW-1:0] second;
  logic [WordW-1:0] s13;
  logic [WordW-1:0] d22;
  logic [WordW-1:0] d30;

  always_comb begin
    s13 = {19'b0, req_i.instr_word[12:0]};
    d22 = {10'b0, req_i.instr_word[21:0]};
    d30 = {2'b0, req_i.instr_word[29:0]};

    if (req_i.instr_word[13]) begin
      second = req_i.instr_word[12] ? (s13 | Simm13Ext) : s13;
    end else begin
      second = req_i.src2_value;
    end

    task_o.is_load        = (req_i.req_type == REQ_LOAD);
    task_o.instr_word     = req_i.instr_word;
    task_o.dest_reg       = req_i.instr_word[29:25];
    task_o.src1_reg       = req_i.instr_word[18:14];
    task_o.src2_reg       = req_i.instr_word[4:0];
    task_o.uses_immediate = req_i.instr_word[13];
    task_o.cond_code      = req_i.instr_word[28:25];
    task_o.eff_address    = req_i.src1_value + second;
    task_o.branch_disp    = req_i.instr_word[21] ? (d22 | Disp22Ext) : d22;
    task_o.call_disp      = {d30[29:0], 2'b00};
    task_o.entry_slot     = req_i.entry_slot;
    task_o.entry_mask     = req_i.entry_mask;
    task_o.entry_pattern  = req_i.entry_pattern;
  end

endmodule

// ===== hdl/mmid_queue.sv =====
// ----------------------------------------------------------------------------
// mmid_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module mmid_queue import mmid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mmid_task_t task_i,
  input  logic       pop_i,
  output mmid_task_t task_o,
  output logic       empty_o,
  output logic       full_o
);

  mmid_task_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= task_i;
    end
  end

  assign task_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

endmodule

// ===== hdl/mmid_back.sv =====
// ----------------------------------------------------------------------------
// mmid_back
// Executes loads and runs the pattern table scan with hit counting.
// ----------------------------------------------------------------------------
module mmid_back import mmid_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [EntryCntW-1:0] entry_count_i,
  input  logic                 empty_i,
  input  mmid_task_t           task_i,
  output logic                 pop_o,
  output logic                 rsp_valid_o,
  output mmid_rsp_t            rsp_o
);

  localparam int unsigned IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned PatW = 2 * WordW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_HIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  mmid_task_t       cur_q, cur_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             chk_v_q, chk_v_d;
  logic [CntW-1:0]  chk_idx_q, chk_idx_d;
  logic [CntW-1:0]  hit_idx_q, hit_idx_d;
  logic [WordW-1:0] hit_new_q, hit_new_d;
  logic [WordW-1:0] total_q, total_d;
  logic             rsp_valid_q, rsp_valid_d;
  mmid_rsp_t        rsp_q, rsp_d;

  logic [CntW-1:0]  limit;
  logic             issue;
  logic             slot_ok;
  logic             hit;
  logic             pat_we;
  logic             cnt_we;
  logic [IdxW-1:0]  waddr;
  logic [WordW-1:0] cnt_wdata;
  logic [PatW-1:0]  pat_rdata;
  logic [WordW-1:0] cnt_rdata;

  function automatic mmid_rsp_t decoded(mmid_task_t t, logic [WordW-1:0] total);
    mmid_rsp_t r;
    r                = '0;
    r.dest_reg       = t.dest_reg;
    r.src1_reg       = t.src1_reg;
    r.src2_reg       = t.src2_reg;
    r.uses_immediate = t.uses_immediate;
    r.cond_code      = t.cond_code;
    r.eff_address    = t.eff_address;
    r.branch_disp    = t.branch_disp;
    r.call_disp      = t.call_disp;
    r.total_hits     = total;
    return r;
  endfunction

  mmid_ram #(
    .WIDTH (PatW),
    .DEPTH (NUM_ENTRIES)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (waddr),
    .wdata_i ({cur_q.entry_mask, cur_q.entry_pattern}),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (pat_rdata)
  );

  mmid_ram #(
    .WIDTH (WordW),
    .DEPTH (NUM_ENTRIES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    if ({24'b0, entry_count_i} > 32'(NUM_ENTRIES)) begin
      limit = CntW'(NUM_ENTRIES);
    end else begin
      limit = CntW'(entry_count_i);
    end
    slot_ok = ({25'b0, cur_q.entry_slot} < 32'(NUM_ENTRIES));
    hit     = chk_v_q &&
              ((cur_q.instr_word & pat_rdata[PatW-1:WordW]) == pat_rdata[WordW-1:0]);
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    iss_d       = iss_q;
    hit_idx_d   = hit_idx_q;
    hit_new_d   = hit_new_q;
    total_d     = total_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    pop_o       = 1'b0;
    issue       = 1'b0;
    pat_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    waddr       = IdxW'(cur_q.entry_slot);

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = task_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        iss_d = '0;
        if (cur_q.is_load) begin
          pat_we      = slot_ok;
          cnt_we      = slot_ok;
          rsp_valid_d = 1'b1;
          rsp_d       = '0;
          rsp_d.total_hits = total_q;
          state_d     = S_IDLE;
        end else if (limit == '0) begin
          rsp_valid_d = 1'b1;
          rsp_d       = decoded(cur_q, total_q);
          state_d     = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = (iss_q < limit);
        if (issue) begin
          iss_d = iss_q + CntW'(1);
        end
        if (hit) begin
          hit_idx_d = chk_idx_q;
          hit_new_d = cnt_rdata + 32'd1;
          state_d   = S_HIT;
        end else if (chk_v_q && ((chk_idx_q + CntW'(1)) == limit)) begin
          rsp_valid_d = 1'b1;
          rsp_d       = decoded(cur_q, total_q);
          state_d     = S_IDLE;
        end
      end
      S_HIT: begin
        cnt_we            = 1'b1;
        waddr             = hit_idx_q[IdxW-1:0];
        cnt_wdata         = hit_new_q;
        total_d           = total_q + 32'd1;
        rsp_valid_d       = 1'b1;
        rsp_d             = decoded(cur_q, total_q + 32'd1);
        rsp_d.matched     = 1'b1;
        rsp_d.match_index = MatchIdxW'(hit_idx_q);
        rsp_d.entry_hits  = hit_new_q;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    chk_v_d   = issue;
    chk_idx_d = iss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_v_q     <= 1'b0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_v_q     <= chk_v_d;
      total_q     <= total_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    iss_q     <= iss_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_new_q <= hit_new_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== hdl/mask_match_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// mask_match_instruction_decoder
// Instruction field decoder with a mask/value pattern table and hit counters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with rsp_valid_o, and the receiver
// cannot stall it. Requests wait in a two-entry queue; busy rises only when
// that queue is full. A decode scans the pattern memory one entry per cycle
// through its single read port and gives its result at the first match, or
// once all k = min(entry_count, NUM_ENTRIES) entries are checked without
// one, or with no scan when k is zero; items are worked one at a time. The
// pattern table holds garbage until loaded and needs no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module mask_match_instruction_decoder import mmid_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mmid_req_t            req_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [EntryCntW-1:0] cfg_data_i,
  output logic                 rsp_valid_o,
  output mmid_rsp_t            rsp_o
);

  logic [EntryCntW-1:0] entry_count_q;
  mmid_task_t           front_task;
  mmid_task_t           head_task;
  logic                 push;
  logic                 pop;
  logic                 empty;
  logic                 full;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;
  assign push        = start && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_data_i;
    end
  end

  mmid_front u_front (
    .req_i  (req_i),
    .task_o (front_task)
  );

  mmid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .task_i  (front_task),
    .pop_i   (pop),
    .task_o  (head_task),
    .empty_o (empty),
    .full_o  (full)
  );

  mmid_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .empty_i       (empty),
    .task_i        (head_task),
    .pop_o         (pop),
    .rsp_valid_o   (rsp_valid_o),
    .rsp_o         (rsp_o)
  );

endmodule

// ===== tb/sv/mask_match_instruction_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// mask_match_instruction_decoder_tb
// Self-checking bench for the mask/match instruction decoder. Requests and
// table loads are queued by the stimulus process and issued by a clocked
// driver with random gaps. Each accepted request runs through a local model
// of the pattern table, hit counters and field decode. A clocked monitor
// checks every result strobe, field by field, against the oldest prediction.
// The entry count is changed only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module mask_match_instruction_decoder_tb import mmid_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 128;
  localparam int unsigned ItemTarget = 1640;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = NumEntries + 12;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  mmid_req_t            req_i       = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [EntryCntW-1:0] cfg_data_i  = '0;
  logic                 rsp_valid_o;
  mmid_rsp_t            rsp_o;

  mask_match_instruction_decoder #(
    .NUM_ENTRIES(NumEntries)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the pattern table and counters
  logic [WordW-1:0]     tbl_mask  [NumEntries];
  logic [WordW-1:0]     tbl_value [NumEntries];
  logic [WordW-1:0]     tbl_hits  [NumEntries];
  logic [WordW-1:0]     total_hits = '0;
  logic [EntryCntW-1:0] entry_limit = '0;

  mmid_req_t   issue_q[$];
  mmid_rsp_t   awaited_rsp_q[$];
  mmid_rsp_t   want_rsp;
  int unsigned idle_left    = 0;
  int unsigned n_issued     = 0;
  int unsigned rsp_count    = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  bit          steady_issue = 1'b0;

  function automatic mmid_rsp_t decode_and_count(input mmid_req_t r);
    mmid_rsp_t        rsp;
    logic [WordW-1:0] w;
    logic [WordW-1:0] second;
    int unsigned      bound;
    int unsigned      k;
    rsp = '0;
    if (r.req_type == REQ_LOAD) begin
      tbl_mask[r.entry_slot]  = r.entry_mask;
      tbl_value[r.entry_slot] = r.entry_pattern;
      tbl_hits[r.entry_slot]  = '0;
      rsp.total_hits = total_hits;
      return rsp;
    end
    w = r.instr_word;
    rsp.dest_reg       = w[29:25];
    rsp.src1_reg       = w[18:14];
    rsp.src2_reg       = w[4:0];
    rsp.uses_immediate = w[13];
    rsp.cond_code      = w[28:25];
    second = w[13] ? {{19{w[12]}}, w[12:0]} : r.src2_value;
    rsp.eff_address = r.src1_value + second;
    rsp.branch_disp = {{10{w[21]}}, w[21:0]};
    rsp.call_disp   = {w[29:0], 2'b00};
    bound = (32'(entry_limit) > NumEntries) ? NumEntries : 32'(entry_limit);
    for (k = 0; k < bound; k++) begin
      if ((w & tbl_mask[k]) == tbl_value[k]) break;
    end
    if (k < bound) begin
      tbl_hits[k] = tbl_hits[k] + 1;
      total_hits  = total_hits + 1;
      rsp.matched     = 1'b1;
      rsp.match_index = MatchIdxW'(k);
      rsp.entry_hits  = tbl_hits[k];
    end
    rsp.total_hits = total_hits;
    return rsp;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_issue || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WordW-1:0] rand_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 20) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [WordW-1:0] rand_mask();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 40) return $urandom | $urandom;
    if (r < 80) return $urandom;
    return $urandom & $urandom;
  endfunction

  function automatic mmid_req_t decode_req(input logic [WordW-1:0] w,
                                           input logic [WordW-1:0] a,
                                           input logic [WordW-1:0] b);
    mmid_req_t r;
    r.req_type      = REQ_DECODE;
    r.instr_word    = w;
    r.src1_value    = a;
    r.src2_value    = b;
    r.entry_slot    = SlotW'($urandom);
    r.entry_mask    = $urandom;
    r.entry_pattern = $urandom;
    return r;
  endfunction

  function automatic mmid_req_t load_req(input logic [SlotW-1:0] slot,
                                         input logic [WordW-1:0] m,
                                         input logic [WordW-1:0] v);
    mmid_req_t r;
    r.req_type      = REQ_LOAD;
    r.instr_word    = $urandom;
    r.src1_value    = $urandom;
    r.src2_value    = $urandom;
    r.entry_slot    = slot;
    r.entry_mask    = m;
    r.entry_pattern = v;
    return r;
  endfunction

  // mostly decodes aimed at a live entry, some reloads and plain noise
  function automatic mmid_req_t make_random_item();
    mmid_req_t        r;
    int unsigned      pick;
    int unsigned      bound;
    int unsigned      j;
    logic [WordW-1:0] m;
    r = decode_req($urandom, rand_operand(), rand_operand());
    pick  = $urandom_range(0, 99);
    bound = (32'(entry_limit) > NumEntries) ? NumEntries : 32'(entry_limit);
    if (pick < 12) begin
      m = rand_mask();
      r = load_req(SlotW'($urandom), m, (pick < 11) ? ($urandom & m) : $urandom);
    end else if (pick < 80 && bound != 0) begin
      j = $urandom_range(0, bound - 1);
      r.instr_word = (r.instr_word & ~tbl_mask[j]) | tbl_value[j];
    end else if (pick < 86) begin
      r.instr_word = rand_operand();
    end
    return r;
  endfunction

  task automatic queue_item(input mmid_req_t r);
    issue_q.push_back(r);
    n_issued++;
  endtask

  task automatic write_entry_count(input logic [EntryCntW-1:0] n);
    @(posedge clk_i);
    cfg_data_i  <= n;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    entry_limit = n;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle(input int unsigned tail);
    while (issue_q.size() != 0 || start || awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic report_failure(input string what);
    $display("mismatch at transfer %0d: %s", rsp_count, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] got,
                             input logic [WordW-1:0] want);
    if (got !== want) report_failure($sformatf("%s got %h want %h", name, got, want));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!start || !busy) begin
      if (start) awaited_rsp_q.push_back(decode_and_count(req_i));
      if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (issue_q.size() != 0) begin
        req_i     <= issue_q.pop_front();
        start     <= 1'b1;
        idle_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (awaited_rsp_q.size() == 0) begin
        report_failure("result with none expected");
      end else begin
        want_rsp = awaited_rsp_q.pop_front();
        check_field("matched", WordW'(rsp_o.matched), WordW'(want_rsp.matched));
        check_field("match_index", WordW'(rsp_o.match_index),
                    WordW'(want_rsp.match_index));
        check_field("dest_reg", WordW'(rsp_o.dest_reg), WordW'(want_rsp.dest_reg));
        check_field("src1_reg", WordW'(rsp_o.src1_reg), WordW'(want_rsp.src1_reg));
        check_field("src2_reg", WordW'(rsp_o.src2_reg), WordW'(want_rsp.src2_reg));
        check_field("uses_immediate", WordW'(rsp_o.uses_immediate),
                    WordW'(want_rsp.uses_immediate));
        check_field("cond_code", WordW'(rsp_o.cond_code), WordW'(want_rsp.cond_code));
        check_field("eff_address", rsp_o.eff_address, want_rsp.eff_address);
        check_field("branch_disp", rsp_o.branch_disp, want_rsp.branch_disp);
        check_field("call_disp", rsp_o.call_disp, want_rsp.call_disp);
        check_field("entry_hits", rsp_o.entry_hits, want_rsp.entry_hits);
        check_field("total_hits", rsp_o.total_hits, want_rsp.total_hits);
      end
      rsp_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[mask_match_instruction_decoder] ERROR");
      $finish;
    end
  end

  logic [EntryCntW-1:0] count_plan [8] = '{8'd1, 8'd255, 8'd2, 8'd200,
                                           8'd0, 8'd127, 8'd64, 8'd128};

  initial begin
    int unsigned          phase;
    logic [EntryCntW-1:0] n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_entry_count('0);

    // empty table in use: decode extremes and load results
    queue_item(decode_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    queue_item(decode_req(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    queue_item(decode_req(32'h0000_3000, 32'h0000_0001, 32'h0000_0000));
    queue_item(decode_req(32'h0000_2fff, 32'h7fff_ffff, 32'h0000_0000));
    queue_item(decode_req(32'h0000_1fff, 32'h8000_0000, 32'hffff_ffff));
    queue_item(decode_req(32'h0020_0000, 32'hffff_ffff, 32'h0000_0001));
    queue_item(decode_req(32'h001f_ffff, 32'h0000_0000, 32'h8000_0000));
    queue_item(decode_req(32'h3fff_ffff, 32'h1234_5678, 32'h8765_4321));
    queue_item(decode_req(32'hc000_0000, 32'h0000_0000, 32'hffff_ffff));
    queue_item(load_req(7'd0, 32'hffff_ffff, 32'hffff_ffff));
    queue_item(load_req(7'd127, 32'h0000_0000, 32'h0000_0000));
    wait_idle(8);

    // fill every entry before any of them is matched against
    for (int unsigned s = 0; s < NumEntries; s++) begin
      if (s == 0) queue_item(load_req(SlotW'(s), 32'hffff_ffff, 32'hcafe_f00d));
      else if (s == NumEntries - 1) queue_item(load_req(SlotW'(s), '0, '0));
      else queue_item(load_req(SlotW'(s), rand_mask(), $urandom));
    end
    for (int unsigned s = 1; s < NumEntries - 1; s++) tbl_value[s] = tbl_value[s];
    wait_idle(8);

    write_entry_count(8'd128);
    queue_item(decode_req(32'hcafe_f00d, 32'h0000_0010, 32'h0000_0020));
    queue_item(decode_req(32'hcafe_f00d, 32'hffff_ffff, 32'h0000_0001));
    queue_item(decode_req(32'hcafe_f00c, 32'h0000_0000, 32'h0000_0000));
    queue_item(decode_req($urandom, $urandom, $urandom));
    wait_idle(8);

    phase = 0;
    while (n_issued < ItemTarget) begin
      n = (phase < 8) ? count_plan[phase] : EntryCntW'($urandom_range(1, 255));
      steady_issue = phase[0];
      write_entry_count(n);
      repeat ($urandom_range(80, 160)) queue_item(make_random_item());
      wait_idle(8);
      phase++;
    end

    wait_idle(DrainCycles);
    if (error_count == 0) begin
      $display("[mask_match_instruction_decoder] OK");
    end else begin
      $display("[mask_match_instruction_decoder] ERROR");
    end
    $finish;
  end

endmodule
